// File: rtl/core/b64e_pkg.sv
`default_nettype none

package b64e_pkg;

   // kind of an input beat
   typedef enum logic {
      KIND_DATA = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   // bytes already taken in the current 3-byte group
   typedef enum logic [1:0] {
      PHASE_ZERO = 2'd0,
      PHASE_ONE  = 2'd1,
      PHASE_TWO  = 2'd2
   } phase_type;

   // queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // ASCII constants
   localparam logic [6:0] PAD_CHAR   = 7'd61;  // '='
   localparam logic [6:0] PLUS_CHAR  = 7'd43;  // '+'
   localparam logic [6:0] SLASH_CHAR = 7'd47;  // '/'

   // one queued job: up to three characters from one input beat
   typedef struct packed {
      logic [5:0] sextet0;    // first character index
      logic [5:0] sextet1;    // second character index, unless padded
      logic [1:0] last_idx;   // index of the final character (0..2)
      logic       pad_second; // second character is '='
   } job_type;

   // map a 6-bit value to its alphabet character
   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      logic [6:0] w;
      w = {1'b0, v};
      if (v < 6'd26) begin
         sextet_char = w + 7'd65;
      end else if (v < 6'd52) begin
         sextet_char = w + 7'd71;
      end else if (v < 6'd62) begin
         sextet_char = w - 7'd4;
      end else if (v == 6'd62) begin
         sextet_char = PLUS_CHAR;
      end else begin
         sextet_char = SLASH_CHAR;
      end
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/b64e_front.sv
`default_nettype none

module b64e_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic              in_kind,
   input  wire logic [7:0]        in_byte,
   input  wire logic              q_full,
   output logic                   push,
   output b64e_pkg::job_type      push_job
);

   b64e_pkg::phase_type phase_ff, phase_in;
   logic [3:0]          carry_ff, carry_in;
   logic                accept;
   logic                job_valid;
   logic                is_end;

   assign in_ready = !q_full;
   assign accept   = in_valid && !q_full;
   assign is_end   = (in_kind == b64e_pkg::KIND_END);
   assign push     = accept && job_valid;

   // next phase and carry
   always_comb begin
      phase_in = phase_ff;
      carry_in = carry_ff;
      if (accept) begin
         if (is_end) begin
            phase_in = b64e_pkg::PHASE_ZERO;
            carry_in = 4'd0;
         end else begin
            unique case (phase_ff)
               b64e_pkg::PHASE_ONE: begin
                  phase_in = b64e_pkg::PHASE_TWO;
                  carry_in = in_byte[3:0];
               end
               b64e_pkg::PHASE_TWO: begin
                  phase_in = b64e_pkg::PHASE_ZERO;
                  carry_in = 4'd0;
               end
               default: begin
                  phase_in = b64e_pkg::PHASE_ONE;
                  carry_in = {2'b00, in_byte[1:0]};
               end
            endcase
         end
      end
   end

   // classify the beat into a job for the back end
   always_comb begin
      job_valid           = 1'b1;
      push_job.sextet0    = 6'd0;
      push_job.sextet1    = in_byte[5:0];
      push_job.last_idx   = 2'd0;
      push_job.pad_second = 1'b0;
      if (is_end) begin
         unique case (phase_ff)
            b64e_pkg::PHASE_ONE: begin
               push_job.sextet0    = {carry_ff[1:0], 4'b0000};
               push_job.last_idx   = 2'd2;
               push_job.pad_second = 1'b1;
            end
            b64e_pkg::PHASE_TWO: begin
               push_job.sextet0    = {carry_ff, 2'b00};
               push_job.last_idx   = 2'd1;
               push_job.pad_second = 1'b1;
            end
            default: begin
               job_valid = 1'b0;
            end
         endcase
      end else begin
         unique case (phase_ff)
            b64e_pkg::PHASE_ONE: begin
               push_job.sextet0 = {carry_ff[1:0], in_byte[7:4]};
            end
            b64e_pkg::PHASE_TWO: begin
               push_job.sextet0  = {carry_ff, in_byte[7:6]};
               push_job.last_idx = 2'd1;
            end
            default: begin
               push_job.sextet0 = in_byte[7:2];
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= b64e_pkg::PHASE_ZERO;
         carry_ff <= 4'd0;
      end else begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/b64e_queue.sv
`default_nettype none

module b64e_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire b64e_pkg::job_type push_job,
   output logic                   full,
   input  wire logic              pop,
   output logic                   empty,
   output b64e_pkg::job_type      head_job
);

   b64e_pkg::job_type                  entry_ff [b64e_pkg::QUEUE_DEPTH];
   logic [b64e_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [b64e_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [b64e_pkg::QUEUE_AW:0]        count_ff, count_in;

   assign full     = (count_ff == (b64e_pkg::QUEUE_AW+1)'(b64e_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/b64e_back.sv
`default_nettype none

module b64e_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              q_empty,
   input  wire b64e_pkg::job_type head_job,
   output logic                   pop,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [6:0]             out_char,
   output logic                   out_last
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff;
   logic       last_ff;
   logic [6:0] cur_char;
   logic       cur_last;
   logic       load;

   assign out_valid = valid_ff;
   assign out_char  = char_ff;
   assign out_last  = last_ff;

   assign load     = !q_empty && (!valid_ff || out_ready);
   assign cur_last = (idx_ff == head_job.last_idx);
   assign pop      = load && cur_last;

   // select the character at the current index of the head job
   always_comb begin
      case (idx_ff)
         2'd0:    cur_char = b64e_pkg::sextet_char(head_job.sextet0);
         2'd1:    cur_char = head_job.pad_second ? b64e_pkg::PAD_CHAR
                                                 : b64e_pkg::sextet_char(head_job.sextet1);
         default: cur_char = b64e_pkg::PAD_CHAR;
      endcase
   end

   // advance index, drop valid once taken
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = cur_last ? 2'd0 : idx_ff + 2'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= cur_char;
         last_ff <= cur_last;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/base64_stream_encoder.sv
`default_nettype none
// Streaming Base64 encoder, standard alphabet with '=' padding.
// Input channel req_*: one beat per byte. req_tuser = 0 carries a data byte in
// req_tdata; req_tuser = 1 ends the message and flushes the partial character
// and padding (req_tdata ignored). An end beat after a full group gives nothing.
// Result channel rsp_*: one ASCII character per beat in rsp_tdata[6:0];
// rsp_tlast marks the final character caused by one input beat.
// The job for an input beat enters the queue at the accepting edge, and the back
// end then loads the output register from the head of the queue. Throughput:
// one character per cycle on rsp while jobs are queued and rsp_tready is high;
// a data byte gives one or two characters (4/3 on average), an end beat up to
// three; the output register, which holds a single character, sets this rate.
// The front end classifies each beat into a job in a four-entry queue; the
// back end serializes jobs. req_tready drops only when the queue is full, so
// a stalled receiver backs up the queue and then the input, without loss.
// Reset (synchronous, active high) empties the queue, drops rsp_tvalid and
// returns the encoder to the start of a group.

module base64_stream_encoder (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] byte_value
   input  wire logic       req_tuser,   // [0] kind
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [6:0] char_code, [7] zero
   output logic            rsp_tlast
);

   logic              q_full;
   logic              q_empty;
   logic              push;
   logic              pop;
   b64e_pkg::job_type push_job;
   b64e_pkg::job_type head_job;
   logic [6:0]        char_code;

   b64e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_kind  (req_tuser),
      .in_byte  (req_tdata),
      .q_full   (q_full),
      .push     (push),
      .push_job (push_job)
   );

   b64e_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (pop),
      .empty    (q_empty),
      .head_job (head_job)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head_job  (head_job),
      .pop       (pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_char  (char_code),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, char_code};

`ifndef SYNTHESIS
   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      !(push && q_full))
      else $error("job pushed into a full queue");

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      !(pop && q_empty))
      else $error("job popped from an empty queue");

   a_reset_clears_out : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

// File: tb/base64_stream_encoder_test.sv
`timescale 1ns / 100ps

module base64_stream_encoder_test;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int BEATS_PER_MODE = 115;

   // one expected character beat
   typedef struct {
      logic [6:0] code;
      logic       last;
   } char_beat_type;

   // Tracks the group phase and leftover bits and queues the expected characters
   class b64_char_scoreboard;
      b64e_pkg::phase_type phase;
      logic [3:0]          carry;
      char_beat_type       pending_chars[$];
      int                  errors;
      string               alphabet_map =
         "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

      function new();
         phase  = b64e_pkg::PHASE_ZERO;
         carry  = 4'd0;
         errors = 0;
      endfunction

      function logic [6:0] encode_sextet(logic [5:0] v);
         logic [7:0] ch;
         ch = alphabet_map[int'(v)];
         return ch[6:0];
      endfunction

      function void push_char(logic [6:0] code, logic last);
         char_beat_type c;
         c.code = code;
         c.last = last;
         pending_chars.push_back(c);
      endfunction

      // advance the encoder state for one accepted input beat
      function void note_beat(b64e_pkg::kind_type kind, logic [7:0] b);
         if (kind == b64e_pkg::KIND_DATA) begin
            case (phase)
               b64e_pkg::PHASE_ONE: begin
                  push_char(encode_sextet({carry[1:0], b[7:4]}), 1'b1);
                  carry = b[3:0];
                  phase = b64e_pkg::PHASE_TWO;
               end
               b64e_pkg::PHASE_TWO: begin
                  push_char(encode_sextet({carry, b[7:6]}), 1'b0);
                  push_char(encode_sextet(b[5:0]), 1'b1);
                  carry = 4'd0;
                  phase = b64e_pkg::PHASE_ZERO;
               end
               default: begin
                  // start of a group, and the unused phase code
                  push_char(encode_sextet(b[7:2]), 1'b1);
                  carry = {2'b00, b[1:0]};
                  phase = b64e_pkg::PHASE_ONE;
               end
            endcase
         end else begin
            // flush the partial character and pad out the group
            case (phase)
               b64e_pkg::PHASE_ONE: begin
                  push_char(encode_sextet({carry[1:0], 4'b0000}), 1'b0);
                  push_char(b64e_pkg::PAD_CHAR, 1'b0);
                  push_char(b64e_pkg::PAD_CHAR, 1'b1);
               end
               b64e_pkg::PHASE_TWO: begin
                  push_char(encode_sextet({carry, 2'b00}), 1'b0);
                  push_char(b64e_pkg::PAD_CHAR, 1'b1);
               end
               default: ;
            endcase
            carry = 4'd0;
            phase = b64e_pkg::PHASE_ZERO;
         end
      endfunction

      // compare one result beat against the oldest expectation
      function void check_char(logic [7:0] data, logic last);
         char_beat_type want;
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected character: expected none, got 0x%02h last %0b",
                     $time, data, last);
            errors++;
            return;
         end
         want = pending_chars.pop_front();
         if (data !== {1'b0, want.code}) begin
            $display("%0t: char mismatch: expected 0x%02h, got 0x%02h",
                     $time, {1'b0, want.code}, data);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return pending_chars.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'd0;   // [7:0] byte_value
   logic       req_tuser = 1'b0;   // [0] kind
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;          // [6:0] char_code, [7] zero
   logic       rsp_tlast;

   b64_char_scoreboard sb;
   int send_idle_pct = 24;
   int recv_idle_pct = 63;
   int hold_off_order = 0;
   int hold_off_left = 0;
   int beats_sent = 0;
   int quiet_cycles = 0;

   base64_stream_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // check result beats, then pick the next ready: long hold-off or random stall
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_char(rsp_tdata, rsp_tlast);
      end
      if (hold_off_order > 0) begin
         hold_off_left = hold_off_order;
         hold_off_order = 0;
      end
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // end the run if neither side moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // offer one beat after a random gap and hold it until accepted
   task automatic send_beat(input b64e_pkg::kind_type kind, input logic [7:0] value);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_beat(kind, value);
      beats_sent++;
   endtask

   task automatic send_end();
      send_beat(b64e_pkg::KIND_END, 8'($urandom_range(255)));
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // stop offering until every queued character has come out
   task automatic pause_until_drained();
      req_tvalid <= 1'b0;
      wait_drained();
      @(posedge clock);
   endtask

   // random message: mostly short, with stray ends and unterminated runs as noise
   task automatic send_message();
      int len;
      int pick;
      pick = $urandom_range(99);
      len = (pick < 85) ? $urandom_range(8) : $urandom_range(20);
      for (int i = 0; i < len; i++) begin
         send_beat(b64e_pkg::KIND_DATA, 8'($urandom_range(255)));
      end
      pick = $urandom_range(99);
      if (pick < 80) begin
         send_end();
      end else if (pick < 90) begin
         send_end();
         send_end();
      end
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // end on an empty group gives nothing
      send_end();
      // two bytes, then flush with one pad
      send_beat(b64e_pkg::KIND_DATA, 8'h00);
      send_beat(b64e_pkg::KIND_DATA, 8'hFF);
      send_end();
      // one byte, then flush with two pads
      send_beat(b64e_pkg::KIND_DATA, 8'hFF);
      send_end();
      // full group, end gives nothing
      send_beat(b64e_pkg::KIND_DATA, 8'h4D);
      send_beat(b64e_pkg::KIND_DATA, 8'h61);
      send_beat(b64e_pkg::KIND_DATA, 8'h6E);
      send_end();
      // plus and slash characters
      send_beat(b64e_pkg::KIND_DATA, 8'hFB);
      send_beat(b64e_pkg::KIND_DATA, 8'hEF);
      send_beat(b64e_pkg::KIND_DATA, 8'hBE);
      send_beat(b64e_pkg::KIND_DATA, 8'hFF);
      send_beat(b64e_pkg::KIND_DATA, 8'hFF);
      send_beat(b64e_pkg::KIND_DATA, 8'hFF);
      send_end();
      // one leftover byte with low bits set
      send_beat(b64e_pkg::KIND_DATA, 8'h03);
      send_end();
      pause_until_drained();

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 24;
               recv_idle_pct = 63;
               // long receiver hold-off while input keeps coming
               hold_off_order = 120;
            end
            1: begin
               send_idle_pct = 63;
               recv_idle_pct = 24;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         while (beats_sent < 20 + BEATS_PER_MODE * (mode + 1)) begin
            send_message();
            if (mode == 1 && $urandom_range(9) == 0) begin
               pause_until_drained();
            end
         end
      end

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
